>>> rtl/software_timer_table_macros.svh
// ----------------------------------------------------------------------------
// Software timer table assertion macros
// Shared property templates for the port-level checker.
// ----------------------------------------------------------------------------
`ifndef SOFTWARE_TIMER_TABLE_MACROS_SVH
`define SOFTWARE_TIMER_TABLE_MACROS_SVH

// Same-cycle implication, disabled while reset is low
`define STT_ASSERT_IMP(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("software_timer_table: same-cycle check failed");

// Next-cycle implication, disabled while reset is low
`define STT_ASSERT_NEXT(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("software_timer_table: next-cycle check failed");

`endif

>>> rtl/stt_pkg.sv
// ----------------------------------------------------------------------------
// stt_pkg
// Types and constants shared by the software timer table modules.
// ----------------------------------------------------------------------------
`default_nettype none

package stt_pkg;

    // Default number of timer slots
    localparam int STT_TIMER_SLOTS = 16;

    // Command codes
    typedef enum logic [1:0] {
        OP_START_ONE    = 2'd0,
        OP_START_RELOAD = 2'd1,
        OP_STOP         = 2'd2,
        OP_TICK         = 2'd3
    } stt_op_t;

    // Status codes on kind-0 words
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NO_SLOT   = 2'd1,
        ST_NOT_FOUND = 2'd2
    } stt_status_t;

    // Result kinds
    localparam logic KIND_STATUS = 1'b0;
    localparam logic KIND_EXPIRY = 1'b1;

    // One slot as held in the slot RAM
    typedef struct packed {
        logic [7:0]  task_id;
        logic [15:0] event_mask;
        logic [31:0] remaining;
        logic [31:0] reload;
    } stt_slot_t;

    // Verdict of the slot unit on the slot under scan
    typedef struct packed {
        logic      match;     // used and keyed by the command's task/event
        logic      vacant;    // slot free
        logic      emit;      // tick: expiry word due
        logic      free_slot; // tick: slot to be freed
        logic      rewrite;   // tick: slot stays, write new_slot back
        stt_slot_t new_slot;
    } stt_slot_res_t;

endpackage

`default_nettype wire

>>> rtl/stt_ram.sv
// ----------------------------------------------------------------------------
// stt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module stt_ram #(
    parameter int  WIDTH  = 8,
    parameter int  DEPTH  = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]  wr_data,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read, old data on a same-address write
    always_ff @(posedge clk) begin
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

>>> rtl/stt_slot_alu.sv
// ----------------------------------------------------------------------------
// stt_slot_alu
// Shared per-slot unit: key compare and saturating countdown of one slot.
// ----------------------------------------------------------------------------
`default_nettype none

module stt_slot_alu
    import stt_pkg::*;
(
    input  wire logic          used,
    input  wire stt_slot_t     slot,
    input  wire logic [7:0]    task_id,
    input  wire logic [15:0]   cmd_event,
    input  wire logic [31:0]   amount,
    output stt_slot_res_t      res
);

    logic [32:0] diff;
    logic        expired;
    logic        ev_live;

    // Countdown: borrow or exact zero means the timer has run out
    assign diff    = {1'b0, slot.remaining} - {1'b0, amount};
    assign expired = diff[32] || (diff[31:0] == 32'd0);
    assign ev_live = (slot.event_mask != 16'd0);

    always_comb begin
        res           = '0;
        res.match     = used && (slot.task_id == task_id) && (slot.event_mask == cmd_event);
        res.vacant    = !used;
        res.emit      = used && ev_live && expired;
        // stopped timers and expired one-shots leave the table
        res.free_slot = used && (!ev_live || (expired && (slot.reload == 32'd0)));
        res.rewrite   = used && !res.free_slot;
        res.new_slot  = slot;
        // expired reloading timers rearm, others keep counting
        res.new_slot.remaining = expired ? slot.reload : diff[31:0];
    end

endmodule

`default_nettype wire

>>> rtl/software_timer_table.sv
// ----------------------------------------------------------------------------
// software_timer_table
// Table of one-shot and reloading timers keyed by task and event, scanned one slot
// per cycle, barring expiry stalls, by a small sequencer around a shared slot unit.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake         | payload
//  s_       | in        | s_valid / s_ready | opcode, task, event, time amount
//  m_       | out       | m_valid / m_ready | kind, status, task, event, clock, last
//
//  Every command passes from acceptance through S_SCAN, which visits each slot
//  in turn through the slot RAM read port and slot unit, to S_FINISH, which
//  loads the last word.
//  A stalled m_ready holds the scan on a slot whose expiry word cannot yet be
//  loaded, and holds the finish cycle. s_ready is high only while idle.
//  Reset (aresetn low, synchronous) frees every slot and zeroes the clock;
//  no clearing pass runs, the slot RAM is only read through used slots.
// ----------------------------------------------------------------------------
`default_nettype none

module software_timer_table
    import stt_pkg::*;
#(
    parameter int TIMER_SLOTS = STT_TIMER_SLOTS
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_opcode,
    input  wire logic [7:0]  s_task_number,
    input  wire logic [15:0] s_event_mask,
    input  wire logic [31:0] s_time_amount,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic             m_result_kind,
    output logic [1:0]       m_status_code,
    output logic [7:0]       m_fired_task,
    output logic [15:0]      m_fired_event,
    output logic [31:0]      m_clock_now,
    output logic             m_last_result
);

    localparam int               IDX_W    = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TIMER_SLOTS - 1);

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_SCAN   = 3'b010,
        S_FINISH = 3'b100
    } state_t;

    // Control state
    state_t                 state_reg, state_next;
    logic [IDX_W-1:0]       idx_reg, idx_next;
    logic [31:0]            clock_reg, clock_next;
    logic [TIMER_SLOTS-1:0] used_reg, used_next;
    logic                   found_reg, found_next;
    logic                   vacant_found_reg, vacant_found_next;
    logic                   m_valid_reg, m_valid_next;

    // Command and scan payload
    stt_op_t                op_reg;
    logic [7:0]             task_reg;
    logic [15:0]            event_reg;
    logic [31:0]            amount_reg;
    logic [IDX_W-1:0]       match_idx_reg, match_idx_next;
    stt_slot_t              match_word_reg, match_word_next;
    logic [IDX_W-1:0]       vacant_idx_reg, vacant_idx_next;

    // Output word registers
    logic                   out_kind_reg;
    stt_status_t            out_status_reg;
    logic [7:0]             out_task_reg;
    logic [15:0]            out_event_reg;
    logic [31:0]            out_clock_reg;
    logic                   out_last_reg;

    // Sequencer outputs
    logic                   accept;
    logic                   out_free;
    logic                   load_out;
    logic                   out_kind;
    stt_status_t            out_status;
    logic [7:0]             out_task;
    logic [15:0]            out_event;
    logic                   out_last;
    logic                   ram_we;
    logic [IDX_W-1:0]       ram_waddr;
    stt_slot_t              ram_wdata;
    logic [IDX_W-1:0]       ram_raddr;
    stt_slot_t              ram_rdata;
    stt_slot_res_t          alu_res;

    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == S_IDLE);

    // Slot store
    stt_ram #(
        .WIDTH($bits(stt_slot_t)),
        .DEPTH(TIMER_SLOTS)
    ) u_slot_ram (
        .clk    (aclk),
        .wr_en  (ram_we),
        .wr_addr(ram_waddr),
        .wr_data(ram_wdata),
        .rd_addr(ram_raddr),
        .rd_data(ram_rdata)
    );

    // Shared compare / countdown unit on the slot under scan
    stt_slot_alu u_slot_alu (
        .used     (used_reg[idx_reg]),
        .slot     (ram_rdata),
        .task_id  (task_reg),
        .cmd_event(event_reg),
        .amount   (amount_reg),
        .res      (alu_res)
    );

    // Sequencer
    always_comb begin
        logic      is_tick;
        logic      is_reload;
        logic      advance;
        stt_slot_t wr_word;

        is_tick   = (op_reg == OP_TICK);
        is_reload = (op_reg == OP_START_RELOAD);
        advance   = 1'b0;
        wr_word   = match_word_reg;

        state_next        = state_reg;
        idx_next          = idx_reg;
        clock_next        = clock_reg;
        used_next         = used_reg;
        found_next        = found_reg;
        vacant_found_next = vacant_found_reg;
        match_idx_next    = match_idx_reg;
        match_word_next   = match_word_reg;
        vacant_idx_next   = vacant_idx_reg;

        load_out   = 1'b0;
        out_kind   = KIND_STATUS;
        out_status = ST_OK;
        out_task   = 8'd0;
        out_event  = 16'd0;
        out_last   = 1'b1;
        ram_we     = 1'b0;
        ram_waddr  = idx_reg;
        ram_wdata  = alu_res.new_slot;
        ram_raddr  = '0;

        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    state_next        = S_SCAN;
                    idx_next          = '0;
                    found_next        = 1'b0;
                    vacant_found_next = 1'b0;
                    if (s_opcode == OP_TICK) begin
                        clock_next = clock_reg + s_time_amount;
                    end
                end
            end

            S_SCAN: begin
                // a pending expiry word holds the scan on this slot
                advance = !(is_tick && alu_res.emit) || out_free;

                if (advance) begin
                    ram_raddr = (idx_reg == LAST_IDX) ? '0 : idx_reg + 1'b1;
                end else begin
                    ram_raddr = idx_reg;
                end

                if (advance) begin
                    if (is_tick) begin
                        ram_we = alu_res.rewrite;
                        if (alu_res.free_slot) begin
                            used_next[idx_reg] = 1'b0;
                        end
                        if (alu_res.emit) begin
                            load_out  = 1'b1;
                            out_kind  = KIND_EXPIRY;
                            out_task  = ram_rdata.task_id;
                            out_event = ram_rdata.event_mask;
                            out_last  = 1'b0;
                        end
                    end else begin
                        // lowest matching and lowest vacant slot
                        if (alu_res.match && !found_reg) begin
                            found_next      = 1'b1;
                            match_idx_next  = idx_reg;
                            match_word_next = ram_rdata;
                        end
                        if (alu_res.vacant && !vacant_found_reg) begin
                            vacant_found_next = 1'b1;
                            vacant_idx_next   = idx_reg;
                        end
                    end

                    if (idx_reg == LAST_IDX) begin
                        state_next = S_FINISH;
                    end else begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end

            S_FINISH: begin
                if (out_free) begin
                    load_out   = 1'b1;
                    state_next = S_IDLE;
                    if (op_reg == OP_STOP) begin
                        if (found_reg) begin
                            wr_word.event_mask = 16'd0;
                            ram_we    = 1'b1;
                            ram_waddr = match_idx_reg;
                            ram_wdata = wr_word;
                        end else begin
                            out_status = ST_NOT_FOUND;
                        end
                    end else if (!is_tick) begin
                        wr_word.task_id    = task_reg;
                        wr_word.event_mask = event_reg;
                        wr_word.remaining  = amount_reg;
                        if (found_reg) begin
                            // existing key: remaining, and reload on a reload start
                            if (is_reload) begin
                                wr_word.reload = amount_reg;
                            end
                            ram_we    = 1'b1;
                            ram_waddr = match_idx_reg;
                            ram_wdata = wr_word;
                        end else if (vacant_found_reg) begin
                            wr_word.reload = is_reload ? amount_reg : 32'd0;
                            ram_we    = 1'b1;
                            ram_waddr = vacant_idx_reg;
                            ram_wdata = wr_word;
                            used_next[vacant_idx_reg] = 1'b1;
                        end else begin
                            out_status = ST_NO_SLOT;
                        end
                    end
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase

        if (load_out) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= S_IDLE;
            idx_reg          <= '0;
            clock_reg        <= 32'd0;
            used_reg         <= '0;
            found_reg        <= 1'b0;
            vacant_found_reg <= 1'b0;
            m_valid_reg      <= 1'b0;
        end else begin
            state_reg        <= state_next;
            idx_reg          <= idx_next;
            clock_reg        <= clock_next;
            used_reg         <= used_next;
            found_reg        <= found_next;
            vacant_found_reg <= vacant_found_next;
            m_valid_reg      <= m_valid_next;
        end
    end

    // Command capture and scan trackers
    always_ff @(posedge aclk) begin
        if (accept) begin
            op_reg     <= stt_op_t'(s_opcode);
            task_reg   <= s_task_number;
            event_reg  <= s_event_mask;
            amount_reg <= s_time_amount;
        end
        match_idx_reg  <= match_idx_next;
        match_word_reg <= match_word_next;
        vacant_idx_reg <= vacant_idx_next;
    end

    // Output word register
    always_ff @(posedge aclk) begin
        if (load_out) begin
            out_kind_reg   <= out_kind;
            out_status_reg <= out_status;
            out_task_reg   <= out_task;
            out_event_reg  <= out_event;
            out_clock_reg  <= clock_reg;
            out_last_reg   <= out_last;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_result_kind = out_kind_reg;
    assign m_status_code = out_status_reg;
    assign m_fired_task  = out_task_reg;
    assign m_fired_event = out_event_reg;
    assign m_clock_now   = out_clock_reg;
    assign m_last_result = out_last_reg;

endmodule

`default_nettype wire

>>> rtl/stt_checker.sv
// ----------------------------------------------------------------------------
// stt_checker
// Port-level checks on the software timer table, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "software_timer_table_macros.svh"

module stt_checker (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    input  wire logic        s_ready,
    input  wire logic        m_valid,
    input  wire logic        m_ready,
    input  wire logic        m_result_kind,
    input  wire logic [1:0]  m_status_code,
    input  wire logic [7:0]  m_fired_task,
    input  wire logic [15:0] m_fired_event,
    input  wire logic [31:0] m_clock_now,
    input  wire logic        m_last_result
);

    // the scan owns the block for the whole command
    `STT_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_valid && s_ready, !s_ready)

    // status words carry no timer identity
    `STT_ASSERT_IMP(a_status_clean, aclk, aresetn, m_valid && !m_result_kind,
        m_fired_task == 8'd0 && m_fired_event == 16'd0)

    // an expiry is never the closing word and always reports success
    `STT_ASSERT_IMP(a_expiry_form, aclk, aresetn, m_valid && m_result_kind,
        !m_last_result && m_status_code == 2'd0)

    // a stalled word holds
    `STT_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready,
        m_valid && $stable(m_clock_now))

endmodule

bind software_timer_table stt_checker u_stt_checker (.*);

`default_nettype wire
